// ----- src/ssi_pkg.sv -----
// ----------------------------------------------------------------------------
// ssi_pkg
// widths, result codes and helpers shared by the segment intersection block
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = 2 * COORD_BITS + 1;
  localparam int QUO_W   = COORD_BITS + FRAC_BITS;
  localparam int LO_W    = COORD_BITS + 1;
  localparam int HI_W    = MAG_W - LO_W;
  localparam int PPL_W   = COORD_BITS + LO_W;
  localparam int PPH_W   = COORD_BITS + HI_W;
  localparam int NUM_W   = COORD_BITS + MAG_W + FRAC_BITS;
  localparam int PT_W    = QUO_W + 2;
  localparam int LATENCY = QUO_W + 7;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_CROSS = 2'd1,
    KIND_COLL  = 2'd2
  } kind_t;

  typedef struct packed {
    logic                         hit;
    kind_t                        kind;
    logic signed [31:0]           mid_x;
    logic signed [31:0]           mid_y;
    logic signed [COORD_BITS-1:0] a0x;
    logic signed [COORD_BITS-1:0] a0y;
    logic                         negx;
    logic                         negy;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [PT_W-1:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    if (e > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (e < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return e[31:0];
  endfunction

endpackage

// ----- src/ssi_div.sv -----
// ----------------------------------------------------------------------------
// ssi_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ssi_div (
  input  logic                      clk,
  input  logic [ssi_pkg::NUM_W-1:0] num_i,
  input  logic [ssi_pkg::MAG_W-1:0] den_i,
  output logic [ssi_pkg::QUO_W-1:0] q_o,
  output logic                      rnz_o
);
  import ssi_pkg::*;

  logic [MAG_W-1:0] r_r   [QUO_W];
  logic [QUO_W-1:0] q_r   [QUO_W];
  logic [QUO_W-1:0] lo_r  [QUO_W];
  logic [MAG_W-1:0] den_r [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [MAG_W-1:0] r_in;
    logic [QUO_W-1:0] q_in;
    logic [QUO_W-1:0] lo_in;
    logic [MAG_W-1:0] d_in;
    logic [MAG_W:0]   t;
    logic [MAG_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign r_in  = num_i[NUM_W-1:QUO_W];
      assign q_in  = '0;
      assign lo_in = num_i[QUO_W-1:0];
      assign d_in  = den_i;
    end else begin : g_next
      assign r_in  = r_r[k-1];
      assign q_in  = q_r[k-1];
      assign lo_in = lo_r[k-1];
      assign d_in  = den_r[k-1];
    end

    always_comb begin
      t    = {r_in, lo_in[QUO_W-1]};
      diff = t - {1'b0, d_in};
      ge   = t >= {1'b0, d_in};
    end

    always_ff @(posedge clk) begin
      r_r[k]   <= ge ? diff[MAG_W-1:0] : t[MAG_W-1:0];
      q_r[k]   <= {q_in[QUO_W-2:0], ge};
      lo_r[k]  <= {lo_in[QUO_W-2:0], 1'b0};
      den_r[k] <= d_in;
    end
  end

  assign q_o   = q_r[QUO_W-1];
  assign rnz_o = r_r[QUO_W-1] != '0;

endmodule

// ----- src/segment_segment_intersection.sv -----
// ----------------------------------------------------------------------------
// segment_segment_intersection
// tests two 2d segments for a meeting point, fixed-point result
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  input     start, busy, in_*             word taken when start && !busy
//  result    out_valid, out_*              one cycle strobe, no back-pressure
//
//  one word per cycle, busy is never raised
//  the divider pipeline of one quotient bit per stage follows six stages
//  of products and decisions and is followed by the output register
//  synchronous active-low reset clears the valid line only
//  the receiver cannot stall, so the pipeline never holds
module segment_segment_intersection (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_first_start_x,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_first_start_y,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_first_end_x,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_first_end_y,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_second_start_x,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_second_start_y,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_second_end_x,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_second_end_y,
  output logic                                  out_valid,
  output logic                                  out_hit,
  output logic [1:0]                            out_case_kind,
  output logic signed [31:0]                    out_point_x,
  output logic signed [31:0]                    out_point_y
);
  import ssi_pkg::*;

  localparam logic [1:0] END_A0 = 2'd0;
  localparam logic [1:0] END_A1 = 2'd1;
  localparam logic [1:0] END_B0 = 2'd2;
  localparam logic [1:0] END_B1 = 2'd3;

  logic acc;
  logic [LATENCY-1:0] vld_r;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LATENCY-2:0], acc};
    end
  end

  // stage 1: differences
  logic signed [COORD_BITS-1:0] c1_r [8];
  logic signed [DIFF_W-1:0] dax1_r, day1_r, dbx1_r, dby1_r, wx1_r, wy1_r, ex1_r, ey1_r;

  always_ff @(posedge clk) begin
    c1_r[0] <= in_first_start_x;
    c1_r[1] <= in_first_start_y;
    c1_r[2] <= in_first_end_x;
    c1_r[3] <= in_first_end_y;
    c1_r[4] <= in_second_start_x;
    c1_r[5] <= in_second_start_y;
    c1_r[6] <= in_second_end_x;
    c1_r[7] <= in_second_end_y;
    dax1_r  <= DIFF_W'(in_first_end_x) - DIFF_W'(in_first_start_x);
    day1_r  <= DIFF_W'(in_first_end_y) - DIFF_W'(in_first_start_y);
    dbx1_r  <= DIFF_W'(in_second_end_x) - DIFF_W'(in_second_start_x);
    dby1_r  <= DIFF_W'(in_second_end_y) - DIFF_W'(in_second_start_y);
    wx1_r   <= DIFF_W'(in_second_start_x) - DIFF_W'(in_first_start_x);
    wy1_r   <= DIFF_W'(in_second_start_y) - DIFF_W'(in_first_start_y);
    ex1_r   <= DIFF_W'(in_second_end_x) - DIFF_W'(in_first_start_x);
    ey1_r   <= DIFF_W'(in_second_end_y) - DIFF_W'(in_first_start_y);
  end

  // stage 2: products
  logic signed [COORD_BITS-1:0] c2_r [8];
  logic signed [DIFF_W-1:0] dax2_r, day2_r;
  logic signed [PROD_W-1:0] pd1_r, pd2_r, ps1_r, ps2_r, pt1_r, pt2_r;
  logic signed [PROD_W-1:0] pa1_r, pa2_r, pw1_r, pw2_r, pe1_r, pe2_r;

  always_ff @(posedge clk) begin
    c2_r   <= c1_r;
    dax2_r <= dax1_r;
    day2_r <= day1_r;
    pd1_r  <= dax1_r * dby1_r;
    pd2_r  <= day1_r * dbx1_r;
    ps1_r  <= wx1_r * dby1_r;
    ps2_r  <= wy1_r * dbx1_r;
    pt1_r  <= wx1_r * day1_r;
    pt2_r  <= wy1_r * dax1_r;
    pa1_r  <= dax1_r * dax1_r;
    pa2_r  <= day1_r * day1_r;
    pw1_r  <= dax1_r * wx1_r;
    pw2_r  <= day1_r * wy1_r;
    pe1_r  <= dax1_r * ex1_r;
    pe2_r  <= day1_r * ey1_r;
  end

  // stage 3: cross and dot products
  logic signed [COORD_BITS-1:0] c3_r [8];
  logic signed [DIFF_W-1:0]  dax3_r, day3_r;
  logic signed [CROSS_W-1:0] den3_r, sn3_r, tn3_r, d03_r, d13_r, d23_r;

  always_ff @(posedge clk) begin
    c3_r   <= c2_r;
    dax3_r <= dax2_r;
    day3_r <= day2_r;
    den3_r <= CROSS_W'(pd1_r) - CROSS_W'(pd2_r);
    sn3_r  <= CROSS_W'(ps1_r) - CROSS_W'(ps2_r);
    tn3_r  <= CROSS_W'(pt1_r) - CROSS_W'(pt2_r);
    d03_r  <= CROSS_W'(pa1_r) + CROSS_W'(pa2_r);
    d13_r  <= CROSS_W'(pw1_r) + CROSS_W'(pw2_r);
    d23_r  <= CROSS_W'(pe1_r) + CROSS_W'(pe2_r);
  end

  // stage 4: decisions and collinear midpoint
  logic signed [CROSS_W-1:0] den_n, sn_n, tn_n;
  logic                      cross_ok, coll_ok;
  logic [1:0]                sel_p, sel_q;
  logic signed [DIFF_W-1:0]  sum_x, sum_y;
  logic signed [PT_W-1:0]    ext_x, ext_y;
  logic signed [DIFF_W-1:0]  absx, absy;

  always_comb begin
    den_n    = den3_r < 0 ? -den3_r : den3_r;
    sn_n     = den3_r < 0 ? -sn3_r : sn3_r;
    tn_n     = den3_r < 0 ? -tn3_r : tn3_r;
    cross_ok = den3_r != 0 && sn_n >= 0 && sn_n <= den_n && tn_n >= 0 && tn_n <= den_n;
    coll_ok  = den3_r == 0 && sn3_r == 0;
    if (d13_r >= 0) begin
      if (d23_r >= 0) begin
        if (d03_r > d13_r && d03_r > d23_r) begin
          sel_p = END_B1; sel_q = END_B0;
        end else if (d13_r > d23_r) begin
          sel_p = END_B1; sel_q = END_A1;
        end else begin
          sel_p = END_B0; sel_q = END_A1;
        end
      end else if (d13_r < d03_r) begin
        sel_p = END_B0; sel_q = END_A0;
      end else begin
        sel_p = END_A1; sel_q = END_A0;
      end
    end else if (d23_r < d03_r) begin
      sel_p = END_B1; sel_q = END_A0;
    end else begin
      sel_p = END_A1; sel_q = END_A0;
    end
    sum_x = DIFF_W'(c3_r[{sel_p, 1'b0}]) + DIFF_W'(c3_r[{sel_q, 1'b0}]);
    sum_y = DIFF_W'(c3_r[{sel_p, 1'b1}]) + DIFF_W'(c3_r[{sel_q, 1'b1}]);
    ext_x = PT_W'(sum_x) <<< (FRAC_BITS - 1);
    ext_y = PT_W'(sum_y) <<< (FRAC_BITS - 1);
    absx  = dax3_r < 0 ? -dax3_r : dax3_r;
    absy  = day3_r < 0 ? -day3_r : day3_r;
  end

  side_t                 side4_r, side5_r, side6_r;
  logic [MAG_W-1:0]      den4_r, sn4_r, den5_r;
  logic [COORD_BITS-1:0] magx4_r, magy4_r;
  logic [PPL_W-1:0]      pplx5_r, pply5_r;
  logic [PPH_W-1:0]      pphx5_r, pphy5_r;
  logic [NUM_W-1:0]      numx6_r, numy6_r;
  logic [MAG_W-1:0]      den6_r;

  always_ff @(posedge clk) begin
    side4_r.hit   <= cross_ok || coll_ok;
    side4_r.kind  <= cross_ok ? KIND_CROSS : (coll_ok ? KIND_COLL : KIND_NONE);
    side4_r.mid_x <= sat32(ext_x);
    side4_r.mid_y <= sat32(ext_y);
    side4_r.a0x   <= c3_r[0];
    side4_r.a0y   <= c3_r[1];
    side4_r.negx  <= dax3_r < 0;
    side4_r.negy  <= day3_r < 0;
    den4_r        <= den_n[MAG_W-1:0];
    sn4_r         <= sn_n[MAG_W-1:0];
    magx4_r       <= absx[COORD_BITS-1:0];
    magy4_r       <= absy[COORD_BITS-1:0];
  end

  // stage 5: partial products of direction magnitude and s numerator
  always_ff @(posedge clk) begin
    side5_r <= side4_r;
    den5_r  <= den4_r;
    pplx5_r <= magx4_r * sn4_r[LO_W-1:0];
    pphx5_r <= magx4_r * sn4_r[MAG_W-1:LO_W];
    pply5_r <= magy4_r * sn4_r[LO_W-1:0];
    pphy5_r <= magy4_r * sn4_r[MAG_W-1:LO_W];
  end

  // stage 6: scaled dividend
  always_ff @(posedge clk) begin
    side6_r <= side5_r;
    den6_r  <= den5_r;
    numx6_r <= (NUM_W'(pphx5_r) << (LO_W + FRAC_BITS)) + (NUM_W'(pplx5_r) << FRAC_BITS);
    numy6_r <= (NUM_W'(pphy5_r) << (LO_W + FRAC_BITS)) + (NUM_W'(pply5_r) << FRAC_BITS);
  end

  logic [QUO_W-1:0] qx, qy;
  logic             rnzx, rnzy;

  ssi_div u_div_x (
    .clk   (clk),
    .num_i (numx6_r),
    .den_i (den6_r),
    .q_o   (qx),
    .rnz_o (rnzx)
  );

  ssi_div u_div_y (
    .clk   (clk),
    .num_i (numy6_r),
    .den_i (den6_r),
    .q_o   (qy),
    .rnz_o (rnzy)
  );

  side_t side_r [QUO_W];

  always_ff @(posedge clk) begin
    side_r[0] <= side6_r;
    for (int k = 1; k < QUO_W; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // output stage
  side_t                  sd;
  logic signed [PT_W-1:0] offx, offy, valx, valy;

  always_comb begin
    sd   = side_r[QUO_W-1];
    offx = sd.negx ? -PT_W'(qx) - PT_W'(rnzx) : PT_W'(qx);
    offy = sd.negy ? -PT_W'(qy) - PT_W'(rnzy) : PT_W'(qy);
    valx = (PT_W'(sd.a0x) <<< FRAC_BITS) + offx;
    valy = (PT_W'(sd.a0y) <<< FRAC_BITS) + offy;
  end

  logic               hit_r;
  logic [1:0]         kind_r;
  logic signed [31:0] px_r, py_r;

  always_ff @(posedge clk) begin
    hit_r  <= sd.hit;
    kind_r <= sd.kind;
    case (sd.kind)
      KIND_CROSS: begin
        px_r <= sat32(valx);
        py_r <= sat32(valy);
      end
      KIND_COLL: begin
        px_r <= sd.mid_x;
        py_r <= sd.mid_y;
      end
      default: begin
        px_r <= '0;
        py_r <= '0;
      end
    endcase
  end

  assign out_valid     = vld_r[LATENCY-1];
  assign out_hit       = hit_r;
  assign out_case_kind = kind_r;
  assign out_point_x   = px_r;
  assign out_point_y   = py_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LATENCY out_valid)
    else $error("result word missing after pipeline latency");

  a_hit_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit == (out_case_kind != KIND_NONE)))
    else $error("hit flag disagrees with case kind");

  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_point_x == 0 && out_point_y == 0))
    else $error("nonzero point on a miss");

  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule
